### rtl/svm_pkg.sv
// Shared constants, codes and beat types for the saturating voice mixer.
`timescale 1ns / 1ps

package svm_pkg;

	localparam int MAX_VOICES = 16;
	localparam int ADDR_BITS  = 16;
	localparam int VIDX_BITS  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int COUNT_BITS = $clog2(MAX_VOICES + 1);
	localparam int ACTIVE_W   = 5;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        address;
		logic signed [7:0]  sample_value;
		logic [15:0]        sample_count;
	} item_t;

	typedef struct packed {
		logic signed [7:0]   left_sample;
		logic signed [7:0]   right_sample;
		logic [1:0]          status;
		logic [ACTIVE_W-1:0] active_voices;
	} result_t;

	typedef struct packed {
		logic                  wr_en;
		logic [VIDX_BITS-1:0]  wr_idx;
		logic [ADDR_BITS-1:0]  wr_addr;
		logic [15:0]           wr_left;
		logic                  cnt_en;
		logic [COUNT_BITS-1:0] cnt_val;
	} vt_cmd_t;

endpackage

### rtl/svm_if.sv
// Valid/ready channel interfaces for input items and result beats.
`timescale 1ns / 1ps

interface svm_item_if;
	logic            valid;
	logic            ready;
	svm_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svm_result_if;
	logic              valid;
	logic              ready;
	svm_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/svm_sample_mem.sv
// Sample memory: one write port, one registered read port.
`timescale 1ns / 1ps

module svm_sample_mem (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [svm_pkg::ADDR_BITS-1:0] wr_addr,
	input  logic signed [7:0]             wr_data,
	input  logic                          rd_en,
	input  logic [svm_pkg::ADDR_BITS-1:0] rd_addr,
	output logic signed [7:0]             rd_data
);

	logic signed [7:0] mem [2**svm_pkg::ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/svm_voice_table.sv
// Ordered voice list: next address and samples left per voice, plus the fill count.
`timescale 1ns / 1ps

module svm_voice_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  svm_pkg::vt_cmd_t                cmd,
	input  logic [svm_pkg::VIDX_BITS-1:0]   rd_idx,
	output logic [svm_pkg::ADDR_BITS-1:0]   rd_addr,
	output logic [15:0]                     rd_left,
	output logic [svm_pkg::COUNT_BITS-1:0]  count
);

	logic [svm_pkg::ADDR_BITS-1:0]  addr_q [svm_pkg::MAX_VOICES];
	logic [15:0]                    left_q [svm_pkg::MAX_VOICES];
	logic [svm_pkg::COUNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < svm_pkg::MAX_VOICES; i++) begin
				addr_q[i] <= '0;
				left_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_en) begin
				addr_q[cmd.wr_idx] <= cmd.wr_addr;
				left_q[cmd.wr_idx] <= cmd.wr_left;
			end
			if (cmd.cnt_en) begin
				count_q <= cmd.cnt_val;
			end
		end
	end

	assign rd_addr = addr_q[rd_idx];
	assign rd_left = left_q[rd_idx];
	assign count   = count_q;

endmodule

### rtl/svm_core.sv
// Item sequencer with the shared saturating adder and the result register.
`timescale 1ns / 1ps

module svm_core (
	input  logic                            clk,
	input  logic                            arst_n,
	svm_item_if.sink                        item,
	svm_result_if.source                    result,
	output logic                            mem_wr_en,
	output logic [svm_pkg::ADDR_BITS-1:0]   mem_wr_addr,
	output logic signed [7:0]               mem_wr_data,
	output logic                            mem_rd_en,
	output logic [svm_pkg::ADDR_BITS-1:0]   mem_rd_addr,
	input  logic signed [7:0]               mem_rd_data,
	output svm_pkg::vt_cmd_t                vt_cmd,
	output logic [svm_pkg::VIDX_BITS-1:0]   vt_rd_idx,
	input  logic [svm_pkg::ADDR_BITS-1:0]   vt_rd_addr,
	input  logic [15:0]                     vt_rd_left,
	input  logic [svm_pkg::COUNT_BITS-1:0]  vt_count
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_MIX   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]                     state_q;
	svm_pkg::item_t                 item_q;
	logic [svm_pkg::COUNT_BITS-1:0] idx_q;
	logic [svm_pkg::COUNT_BITS-1:0] kept_q;
	logic signed [7:0]              acc_q;
	logic [1:0]                     status_q;
	logic                           out_valid_q;
	svm_pkg::result_t               out_data_q;

	logic                           accept;
	logic                           out_free;
	logic signed [8:0]              sum;
	logic signed [7:0]              sat;
	logic [15:0]                    rem;
	logic                           last;
	logic [svm_pkg::COUNT_BITS-1:0] kept_next;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	assign sum = {acc_q[7], acc_q} + {mem_rd_data[7], mem_rd_data};
	assign sat = (sum[8] != sum[7]) ? (sum[8] ? 8'sh80 : 8'sh7f) : sum[7:0];
	assign rem = vt_rd_left - 16'd1;
	assign last = (idx_q + 1'b1) == vt_count;
	assign kept_next = (rem != 16'd0) ? kept_q + 1'b1 : kept_q;

	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assign vt_rd_idx   = idx_q[svm_pkg::VIDX_BITS-1:0];
	assign mem_wr_en   = (state_q == S_WRITE);
	assign mem_wr_addr = svm_pkg::ADDR_BITS'(item_q.address);
	assign mem_wr_data = item_q.sample_value;
	assign mem_rd_en   = (state_q == S_FETCH);
	assign mem_rd_addr = vt_rd_addr;

	always_comb begin
		vt_cmd = '0;
		case (state_q)
			S_START: begin
				if (item_q.sample_count != 16'd0 &&
				    vt_count < svm_pkg::COUNT_BITS'(svm_pkg::MAX_VOICES)) begin
					vt_cmd.wr_en   = 1'b1;
					vt_cmd.wr_idx  = vt_count[svm_pkg::VIDX_BITS-1:0];
					vt_cmd.wr_addr = svm_pkg::ADDR_BITS'(item_q.address);
					vt_cmd.wr_left = item_q.sample_count;
					vt_cmd.cnt_en  = 1'b1;
					vt_cmd.cnt_val = vt_count + 1'b1;
				end
			end
			S_MIX: begin
				vt_cmd.wr_en   = (rem != 16'd0);
				vt_cmd.wr_idx  = kept_q[svm_pkg::VIDX_BITS-1:0];
				vt_cmd.wr_addr = vt_rd_addr + 1'b1;
				vt_cmd.wr_left = rem;
				vt_cmd.cnt_en  = last;
				vt_cmd.cnt_val = kept_next;
			end
			default: begin
				vt_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			kept_q      <= '0;
			acc_q       <= '0;
			status_q    <= svm_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && result.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						kept_q   <= '0;
						acc_q    <= '0;
						status_q <= svm_pkg::ST_OK;
						case (item.data.mode)
							svm_pkg::MODE_WRITE: state_q <= S_WRITE;
							svm_pkg::MODE_START: state_q <= S_START;
							svm_pkg::MODE_TICK:
								state_q <= (vt_count == '0) ? S_DONE : S_FETCH;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_START: begin
					if (item_q.sample_count == 16'd0) begin
						status_q <= svm_pkg::ST_ZERO;
					end else if (vt_count >= svm_pkg::COUNT_BITS'(svm_pkg::MAX_VOICES)) begin
						status_q <= svm_pkg::ST_FULL;
					end
					state_q <= S_DONE;
				end
				S_FETCH: begin
					state_q <= S_MIX;
				end
				S_MIX: begin
					acc_q  <= sat;
					kept_q <= kept_next;
					idx_q  <= idx_q + 1'b1;
					state_q <= last ? S_DONE : S_FETCH;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q                <= 1'b1;
						out_data_q.left_sample     <= acc_q;
						out_data_q.right_sample    <= acc_q;
						out_data_q.status          <= status_q;
						out_data_q.active_voices   <= svm_pkg::ACTIVE_W'(vt_count);
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/saturating_voice_mixer_top.sv
// Top level of the saturating voice mixer.
// Input channel item: mode 0 writes sample_value into the sample memory at address,
// mode 1 appends a voice (address, sample_count) to the ordered voice list if the count
// is nonzero and the list not full, mode 2 mixes one stereo frame, mode 3 does nothing.
// Every item returns exactly one beat on the result channel: left and right samples,
// status and the number of active voices. One item is in work at a time; the input is
// not ready from acceptance until the result is loaded into the output register.
// A write or a start passes through its own state before the result is loaded; mode 3
// and a tick with no voices go straight to the result state. Each voice of a tick
// takes a fetch from the registered sample memory read port and a pass through the
// shared saturating adder, which also writes the compacted voice entry back.
// The input is ready again in the same cycle as the result turns valid.
// The output register holds a finished beat while the receiver stalls; the next item
// is accepted meanwhile and waits for the register to drain before its beat is loaded.
// Reset clears the voice list and the sequencer at once; the sample memory keeps no
// reset value and an entry must be written before any voice plays it.
`timescale 1ns / 1ps

module saturating_voice_mixer_top (
	input  logic          clk,
	input  logic          arst_n,
	svm_item_if.sink      item,
	svm_result_if.source  result
);

	logic                           mem_wr_en;
	logic [svm_pkg::ADDR_BITS-1:0]  mem_wr_addr;
	logic signed [7:0]              mem_wr_data;
	logic                           mem_rd_en;
	logic [svm_pkg::ADDR_BITS-1:0]  mem_rd_addr;
	logic signed [7:0]              mem_rd_data;
	svm_pkg::vt_cmd_t               vt_cmd;
	logic [svm_pkg::VIDX_BITS-1:0]  vt_rd_idx;
	logic [svm_pkg::ADDR_BITS-1:0]  vt_rd_addr;
	logic [15:0]                    vt_rd_left;
	logic [svm_pkg::COUNT_BITS-1:0] vt_count;

	svm_sample_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	svm_voice_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (vt_cmd),
		.rd_idx  (vt_rd_idx),
		.rd_addr (vt_rd_addr),
		.rd_left (vt_rd_left),
		.count   (vt_count)
	);

	svm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.vt_cmd      (vt_cmd),
		.vt_rd_idx   (vt_rd_idx),
		.vt_rd_addr  (vt_rd_addr),
		.vt_rd_left  (vt_rd_left),
		.vt_count    (vt_count)
	);

endmodule

### rtl/svm_checker.sv
// Port-level checks for the saturating voice mixer, bound to the top level.
`timescale 1ns / 1ps

module svm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [7:0]            left_sample,
	input logic signed [7:0]            right_sample,
	input logic [1:0]                   status,
	input logic [svm_pkg::ACTIVE_W-1:0] active_voices
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_mono_mix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_sample == right_sample)
		else $error("left and right mix differ");

	a_reject_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != svm_pkg::ST_OK |-> left_sample == 8'sd0 && right_sample == 8'sd0)
		else $error("rejected start carries a sample");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_voices <= svm_pkg::ACTIVE_W'(svm_pkg::MAX_VOICES))
		else $error("active voice count beyond list size");

endmodule

bind saturating_voice_mixer_top svm_checker u_svm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.left_sample   (result.data.left_sample),
	.right_sample  (result.data.right_sample),
	.status        (result.data.status),
	.active_voices (result.data.active_voices)
);

### sim/saturating_voice_mixer_top_tb.sv
// Self-checking testbench for the saturating voice mixer: mixing predictor and random traffic.
`timescale 1ns / 1ps

class mixer_ledger;
	localparam int SAT_HI = 127;
	localparam int SAT_LO = -128;

	logic signed [7:0]             store [0:65535];
	logic [svm_pkg::ADDR_BITS-1:0] v_addr [svm_pkg::MAX_VOICES];
	logic [15:0]                   v_left [svm_pkg::MAX_VOICES];
	int                            v_n;
	svm_pkg::result_t              due_beats [$];
	int                            errors;
	int                            beats;
	int                            ticks;
	int                            clipped;
	int                            full_hits;
	int                            zero_hits;

	function svm_pkg::result_t mix_item(svm_pkg::item_t it);
		svm_pkg::result_t r;
		int acc;
		int kept;
		r = '0;
		case (it.mode)
		svm_pkg::MODE_WRITE: begin
			store[it.address] = it.sample_value;
		end
		svm_pkg::MODE_START: begin
			if (it.sample_count == 16'd0) begin
				r.status = svm_pkg::ST_ZERO;
				zero_hits++;
			end else if (v_n >= svm_pkg::MAX_VOICES) begin
				r.status = svm_pkg::ST_FULL;
				full_hits++;
			end else begin
				v_addr[v_n] = it.address;
				v_left[v_n] = it.sample_count;
				v_n++;
			end
		end
		svm_pkg::MODE_TICK: begin
			acc = 0;
			kept = 0;
			ticks++;
			for (int i = 0; i < v_n; i++) begin
				acc = acc + int'(store[v_addr[i]]);
				if (acc > SAT_HI) begin
					acc = SAT_HI;
					clipped++;
				end else if (acc < SAT_LO) begin
					acc = SAT_LO;
					clipped++;
				end
				if (v_left[i] != 16'd1) begin
					v_addr[kept] = v_addr[i] + 1'b1;
					v_left[kept] = v_left[i] - 1'b1;
					kept++;
				end
			end
			v_n = kept;
			r.left_sample = 8'(acc);
			r.right_sample = 8'(acc);
		end
		default: ;
		endcase
		r.active_voices = svm_pkg::ACTIVE_W'(v_n);
		return r;
	endfunction

	function void note_item(svm_pkg::item_t it);
		due_beats = {due_beats, mix_item(it)};
	endfunction

	function void match_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_beat(svm_pkg::result_t got);
		svm_pkg::result_t want;
		if (due_beats.size() == 0) begin
			$display("%0t: beat with nothing due, actual left %0d right %0d status %0d voices %0d",
				$time, $signed(got.left_sample), $signed(got.right_sample), got.status,
				got.active_voices);
			errors++;
			return;
		end
		want = due_beats.pop_front();
		beats++;
		match_field("left_sample", $signed(want.left_sample), $signed(got.left_sample));
		match_field("right_sample", $signed(want.right_sample), $signed(got.right_sample));
		match_field("status", want.status, got.status);
		match_field("active_voices", want.active_voices, got.active_voices);
	endfunction
endclass

module saturating_voice_mixer_top_tb;

	localparam logic [1:0] MODE_NONE   = 2'd3;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         TAIL_CYCLES = 48;
	localparam int         PHASE_ITEMS = 530;

	typedef struct {
		logic [15:0] base;
		int          len;
	} span_t;

	logic clk;
	logic arst_n;

	svm_item_if   mix_in ();
	svm_result_if mix_out ();

	saturating_voice_mixer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (mix_in),
		.result (mix_out)
	);

	mixer_ledger ledger = new();
	span_t       spans [$];
	int          send_idle = 34;
	int          recv_idle = 59;
	int          items_sent;
	int          cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("saturating_voice_mixer_top verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		mix_out.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && mix_out.valid && mix_out.ready)
			ledger.check_beat(mix_out.data);
	end

	task automatic send_item(logic [1:0] mode, logic [15:0] addr, logic [7:0] val,
			logic [15:0] cnt);
		svm_pkg::item_t it;
		it.mode = mode;
		it.address = addr;
		it.sample_value = val;
		it.sample_count = cnt;
		while ($urandom_range(99) < send_idle) begin
			mix_in.valid <= 1'b0;
			@(negedge clk);
		end
		mix_in.data <= it;
		mix_in.valid <= 1'b1;
		do @(posedge clk); while (mix_in.ready !== 1'b1);
		ledger.note_item(it);
		if (mode != MODE_NONE)
			items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(3))
		0: return 8'h7F;
		1: return 8'h80;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic start_voice();
		span_t s;
		int off;
		s = spans[$urandom_range(spans.size() - 1)];
		off = $urandom_range(s.len - 1);
		send_item(svm_pkg::MODE_START, 16'(s.base + off), 8'($urandom_range(255)),
			16'($urandom_range(1, s.len - off)));
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(svm_pkg::MODE_TICK, 16'($urandom_range(65535)),
			8'($urandom_range(255)), 16'($urandom_range(65535)));
	endtask

	task automatic wait_drained();
		mix_in.valid <= 1'b0;
		while (ledger.due_beats.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_sequence();
		int pick;
		int len;
		int off;
		logic [15:0] base;
		span_t s;
		pick = $urandom_range(99);
		if (pick < 28) begin
			base = ($urandom_range(4) == 0) ? 16'hFFFF - 16'($urandom_range(12))
				: 16'($urandom_range(65535));
			len = $urandom_range(1, 24);
			for (int k = 0; k < len; k++)
				send_item(svm_pkg::MODE_WRITE, 16'(base + k), pick_sample(),
					16'($urandom_range(65535)));
			spans = {spans, span_t'{base, len}};
		end else if (pick < 58) begin
			repeat ($urandom_range(1, 4)) begin
				start_voice();
				if ($urandom_range(3) == 0) begin
					s = spans[$urandom_range(spans.size() - 1)];
					off = $urandom_range(s.len - 1);
					send_item(svm_pkg::MODE_WRITE, 16'(s.base + off), pick_sample(), 16'd0);
				end
			end
			send_ticks($urandom_range(1, 10));
		end else if (pick < 66) begin
			while (ledger.v_n < svm_pkg::MAX_VOICES)
				start_voice();
			repeat ($urandom_range(1, 3))
				send_item(svm_pkg::MODE_START, 16'($urandom_range(65535)),
					8'($urandom_range(255)),
					($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
			send_ticks($urandom_range(4, 26));
		end else if (pick < 74) begin
			send_item(svm_pkg::MODE_START, 16'($urandom_range(65535)),
				8'($urandom_range(255)), 16'd0);
		end else if (pick < 78) begin
			send_item(MODE_NONE, 16'($urandom_range(65535)), 8'($urandom_range(255)),
				16'($urandom_range(65535)));
		end else begin
			send_ticks($urandom_range(1, 6));
		end
	endtask

	task automatic run_phase(int s_pct, int r_pct, int quota);
		int goal;
		send_idle = s_pct;
		recv_idle = r_pct;
		goal = items_sent + quota;
		while (items_sent < goal)
			random_sequence();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		mix_in.valid = 1'b0;
		mix_in.data = '0;
		mix_out.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(svm_pkg::MODE_TICK, 16'h0000, 8'h00, 16'h0000);
		send_item(svm_pkg::MODE_START, 16'hFFFF, 8'h00, 16'h0000);
		send_item(MODE_NONE, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_item(svm_pkg::MODE_WRITE, 16'hFFFF, 8'h7F, 16'h0000);
		send_item(svm_pkg::MODE_WRITE, 16'h0000, 8'h7F, 16'h0000);
		send_item(svm_pkg::MODE_WRITE, 16'h0001, 8'h80, 16'h0000);
		spans = {spans, span_t'{16'hFFFF, 3}};
		send_item(svm_pkg::MODE_START, 16'hFFFF, 8'h00, 16'd3);
		send_item(svm_pkg::MODE_START, 16'hFFFF, 8'h00, 16'd1);
		send_item(svm_pkg::MODE_START, 16'h0001, 8'h00, 16'd1);
		send_ticks(3);
		repeat (svm_pkg::MAX_VOICES) send_item(svm_pkg::MODE_START, 16'h0001, 8'h00, 16'd1);
		send_item(svm_pkg::MODE_START, 16'h8000, 8'h00, 16'hFFFF);
		send_item(svm_pkg::MODE_START, 16'h0000, 8'h00, 16'h0000);
		send_ticks(1);
		wait_drained();

		run_phase(34, 59, PHASE_ITEMS);
		run_phase(59, 34, PHASE_ITEMS);
		run_phase(0, 0, PHASE_ITEMS);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d items: %0d frames with %0d clipped adds,", items_sent,
			ledger.ticks, ledger.clipped);
		$display("%0d full-list and %0d zero-length rejects; compared %0d beats, %0d mismatches.",
			ledger.full_hits, ledger.zero_hits, ledger.beats, ledger.errors);
		if (ledger.errors == 0)
			$display("saturating_voice_mixer_top verification clean");
		else
			$display("saturating_voice_mixer_top verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/svm_pkg.sv
rtl/svm_if.sv
rtl/svm_sample_mem.sv
rtl/svm_voice_table.sv
rtl/svm_core.sv
rtl/saturating_voice_mixer_top.sv
rtl/svm_checker.sv
sim/saturating_voice_mixer_top_tb.sv
